// File: rtl/next_prime_search_core_defines.svh
// Assertion macros for the next-prime search core.
// Used by next_prime_search_core.sv; no other dependencies.
`ifndef NEXT_PRIME_SEARCH_CORE_DEFINES_SVH
`define NEXT_PRIME_SEARCH_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, sampled on clk, off during reset
`define NPS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("next_prime_search_core: same-cycle check failed");

// Next-cycle implication, sampled on clk, off during reset
`define NPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next_prime_search_core: next-cycle check failed");

`else

`define NPS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define NPS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: rtl/nps_pkg.sv
// Shared types for the next-prime search core.
// No dependencies; used by next_prime_search_core.sv.
package nps_pkg;

    // Sequencer states, one-hot
    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_CHECK  = 4'b0010,
        ST_DIVIDE = 4'b0100,
        ST_EVAL   = 4'b1000
    } state_t;

endpackage

// File: rtl/next_prime_search_core.sv
// Next-prime search core: smallest prime at or above a start value, by trial division.
// Depends on nps_pkg.sv and next_prime_search_core_defines.svh.
//
// A transfer is taken when start is high and busy is low; one result per transfer
// follows on prime_value/range_exceeded, marked by done for exactly one cycle and
// never held, so the receiver must take it then. Start values 0 and 1 answer in
// the next cycle (0 and 2). Otherwise each candidate is tested by divisors f = 2,
// 3 and upward while f*f <= candidate; one shared restoring divider forms
// candidate mod f one bit per cycle, and the search visits every candidate up to
// the prime found. range_exceeded is set, with prime_value 0, when no prime lies
// between the start value and 2^VALUE_WIDTH - 1. busy stays high for the whole
// search.
`include "next_prime_search_core_defines.svh"

module next_prime_search_core #(
    parameter int VALUE_WIDTH = 31
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [VALUE_WIDTH-1:0] start_value,
    output logic                   done,
    output logic [VALUE_WIDTH-1:0] prime_value,
    output logic                   range_exceeded
);

    // Divisor width: holds floor(sqrt(2^W)) + 1
    localparam int DW = (VALUE_WIDTH + 1) / 2 + 1;
    // Step counter width: counts VALUE_WIDTH - 1 down to 0
    localparam int CW = $clog2(VALUE_WIDTH);

    nps_pkg::state_t state_reg, state_next;

    logic [VALUE_WIDTH-1:0] cand_reg, cand_next;
    logic [VALUE_WIDTH-1:0] dividend_reg, dividend_next;
    logic [DW-1:0]          div_reg, div_next;
    logic [VALUE_WIDTH:0]   sq_reg, sq_next;
    logic [DW-1:0]          rem_reg, rem_next;
    logic [CW-1:0]          step_reg, step_next;
    logic                   done_reg, done_next;
    logic [VALUE_WIDTH-1:0] prime_reg, prime_next;
    logic                   flag_reg, flag_next;

    // Shared divider datapath: shift in the next dividend bit, trial subtract
    logic [DW:0] shifted;
    logic [DW:0] diff;
    logic        fits;

    assign shifted = {rem_reg, dividend_reg[VALUE_WIDTH-1]};
    assign diff    = shifted - {1'b0, div_reg};
    assign fits    = shifted >= {1'b0, div_reg};

    // Sequencer
    always_comb
    begin
        state_next    = state_reg;
        cand_next     = cand_reg;
        dividend_next = dividend_reg;
        div_next      = div_reg;
        sq_next       = sq_reg;
        rem_next      = rem_reg;
        step_next     = step_reg;
        done_next     = 1'b0;
        prime_next    = prime_reg;
        flag_next     = flag_reg;

        unique case (state_reg)
            nps_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    if (start_value == '0)
                    begin
                        done_next  = 1'b1;
                        prime_next = '0;
                        flag_next  = 1'b0;
                    end
                    else if (start_value == VALUE_WIDTH'(1))
                    begin
                        done_next  = 1'b1;
                        prime_next = VALUE_WIDTH'(2);
                        flag_next  = 1'b0;
                    end
                    else
                    begin
                        cand_next  = start_value;
                        div_next   = DW'(2);
                        sq_next    = (VALUE_WIDTH + 1)'(4);
                        state_next = nps_pkg::ST_CHECK;
                    end
                end
            end

            // Bound test f*f <= candidate; past it the candidate is prime
            nps_pkg::ST_CHECK:
            begin
                if (sq_reg > {1'b0, cand_reg})
                begin
                    done_next  = 1'b1;
                    prime_next = cand_reg;
                    flag_next  = 1'b0;
                    state_next = nps_pkg::ST_IDLE;
                end
                else
                begin
                    rem_next      = '0;
                    dividend_next = cand_reg;
                    step_next     = CW'(VALUE_WIDTH - 1);
                    state_next    = nps_pkg::ST_DIVIDE;
                end
            end

            // One remainder bit per cycle
            nps_pkg::ST_DIVIDE:
            begin
                rem_next      = fits ? diff[DW-1:0] : shifted[DW-1:0];
                dividend_next = {dividend_reg[VALUE_WIDTH-2:0], 1'b0};
                if (step_reg == '0)
                begin
                    state_next = nps_pkg::ST_EVAL;
                end
                else
                begin
                    step_next = step_reg - CW'(1);
                end
            end

            // Divisible: next candidate; else next divisor, (f+1)^2 = f^2 + 2f + 1
            nps_pkg::ST_EVAL:
            begin
                if (rem_reg == '0)
                begin
                    if (cand_reg == '1)
                    begin
                        done_next  = 1'b1;
                        prime_next = '0;
                        flag_next  = 1'b1;
                        state_next = nps_pkg::ST_IDLE;
                    end
                    else
                    begin
                        cand_next  = cand_reg + VALUE_WIDTH'(1);
                        div_next   = DW'(2);
                        sq_next    = (VALUE_WIDTH + 1)'(4);
                        state_next = nps_pkg::ST_CHECK;
                    end
                end
                else
                begin
                    div_next   = div_reg + DW'(1);
                    sq_next    = sq_reg + (VALUE_WIDTH + 1)'({div_reg, 1'b1});
                    state_next = nps_pkg::ST_CHECK;
                end
            end

            default:
            begin
                state_next = nps_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= nps_pkg::ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        cand_reg     <= cand_next;
        dividend_reg <= dividend_next;
        div_reg      <= div_next;
        sq_reg       <= sq_next;
        rem_reg      <= rem_next;
        step_reg     <= step_next;
        prime_reg    <= prime_next;
        flag_reg     <= flag_next;
    end

    assign busy           = (state_reg != nps_pkg::ST_IDLE);
    assign done           = done_reg;
    assign prime_value    = prime_reg;
    assign range_exceeded = flag_reg;

    // Checks
    `NPS_ASSERT_IMPL(a_done_idle, clk, rst_n, done, !busy)
    `NPS_ASSERT_IMPL(a_flag_zero, clk, rst_n, done && range_exceeded, prime_value == '0)
    `NPS_ASSERT_IMPL(a_rem_below_div, clk, rst_n,
        state_reg == nps_pkg::ST_DIVIDE || state_reg == nps_pkg::ST_EVAL, rem_reg < div_reg)
    `NPS_ASSERT_NEXT(a_search_starts, clk, rst_n,
        start && !busy && start_value > VALUE_WIDTH'(1), busy && !done)

endmodule

// File: verif/next_prime_search_checker.sv
// Scoreboard for the next-prime search core: predicts each answer and compares.
// Standalone module; needs only the ports of next_prime_search_core.
`timescale 1ns / 1ps

module next_prime_search_checker #(
    parameter int VALUE_WIDTH = 31
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic                   busy,
    input  logic [VALUE_WIDTH-1:0] start_value,
    input  logic                   done,
    input  logic [VALUE_WIDTH-1:0] prime_value,
    input  logic                   range_exceeded,
    output int                     mismatch_count,
    output int                     answers_pending
);

    typedef struct packed {
        logic [VALUE_WIDTH-1:0] prime;
        logic                   exceeded;
    } prime_answer_t;

    prime_answer_t answer_queue[$];
    prime_answer_t oldest_answer;

    // Smallest prime at or above n; divisors run while f*f <= candidate
    function automatic prime_answer_t search_next_prime(input logic [VALUE_WIDTH-1:0] n);
        longint unsigned top_value;
        longint unsigned cand;
        longint unsigned f;
        bit              composite;
        prime_answer_t   ans;
        top_value = (64'd1 << VALUE_WIDTH) - 64'd1;
        ans = '0;
        if (n == 1)
        begin
            ans.prime = VALUE_WIDTH'(2);
        end
        else if (n != 0)
        begin
            cand = 64'(n);
            forever
            begin
                composite = 1'b0;
                f = 2;
                while (!composite && f <= cand / f)
                begin
                    if (cand % f == 0)
                        composite = 1'b1;
                    f++;
                end
                if (!composite)
                begin
                    ans.prime = cand[VALUE_WIDTH-1:0];
                    break;
                end
                // nothing prime left below the top of the range
                if (cand == top_value)
                begin
                    ans.exceeded = 1'b1;
                    break;
                end
                cand++;
            end
        end
        return ans;
    endfunction

    // Result side first: a result never belongs to a transfer taken at the same edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                if (answer_queue.size() == 0)
                begin
                    $display("%0t: result with no transfer pending: %s %0d %s %0b",
                             $time, "prime_value", prime_value,
                             "range_exceeded", range_exceeded);
                    mismatch_count++;
                end
                else
                begin
                    oldest_answer = answer_queue.pop_front();
                    if (prime_value !== oldest_answer.prime)
                    begin
                        $display("%0t: prime_value mismatch: expected %0d, actual %0d",
                                 $time, oldest_answer.prime, prime_value);
                        mismatch_count++;
                    end
                    if (range_exceeded !== oldest_answer.exceeded)
                    begin
                        $display("%0t: range_exceeded mismatch: expected %0b, actual %0b",
                                 $time, oldest_answer.exceeded, range_exceeded);
                        mismatch_count++;
                    end
                end
            end
            // command transfer
            if (start && !busy)
                answer_queue.push_back(search_next_prime(start_value));
            answers_pending = answer_queue.size();
        end
    end

endmodule

// File: verif/next_prime_search_core_tb.sv
// Testbench top for next_prime_search_core: directed and random start values.
// Depends on next_prime_search_checker.sv and the core RTL.
`timescale 1ns / 1ps

module next_prime_search_core_tb;

    localparam int     VALUE_WIDTH = 31;
    // random starts stay below 2^22
    localparam longint CYCLE_LIMIT = 30_000_000;
    localparam int     RANDOM_STARTS = 100;
    localparam int     TAIL_CYCLES = 40;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   start = 1'b0;
    logic [VALUE_WIDTH-1:0] start_value = '0;
    logic                   busy;
    logic                   done;
    logic [VALUE_WIDTH-1:0] prime_value;
    logic                   range_exceeded;
    int                     mismatch_count;
    int                     answers_pending;
    longint                 cycle_count = 0;

    // zero, one, small primes and squares, prime gaps, 16-bit edges, full-width prime
    logic [VALUE_WIDTH-1:0] directed_starts [21] = '{
        0, 1, 2, 3, 4, 24, 25, 49, 90, 113, 114, 121, 1024, 32767, 65521, 65536,
        1000000, 2147483647, 1, 0, 2
    };

    always #5 clk = ~clk;

    next_prime_search_core #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .start_value   (start_value),
        .done          (done),
        .prime_value   (prime_value),
        .range_exceeded(range_exceeded)
    );

    next_prime_search_checker #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .start_value    (start_value),
        .done           (done),
        .prime_value    (prime_value),
        .range_exceeded (range_exceeded),
        .mismatch_count (mismatch_count),
        .answers_pending(answers_pending)
    );

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("next_prime_search_core regression: fail");
            $finish;
        end
    end

    // Issue one command after gap idle cycles; returns at the falling edge after the transfer
    task automatic issue_search(input logic [VALUE_WIDTH-1:0] value, input int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start       <= 1'b1;
        start_value <= value;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
    endtask

    task automatic wait_all_answers();
        while (answers_pending != 0)
            @(negedge clk);
    endtask

    // Mostly narrow values so the search stays short; a few wider ones
    function automatic logic [VALUE_WIDTH-1:0] draw_start_value();
        int pick;
        int width;
        pick = $urandom_range(0, 99);
        if (pick < 8)
            return VALUE_WIDTH'($urandom_range(0, 3));
        width = (pick < 88) ? $urandom_range(1, 14) : $urandom_range(15, 22);
        return VALUE_WIDTH'($urandom_range(0, (1 << width) - 1));
    endfunction

    initial
    begin
        int  i;
        bit  burst;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed starts; every third back to back
        foreach (directed_starts[k])
            issue_search(directed_starts[k], (k % 3 == 0) ? 0 : $urandom_range(1, 5));

        start <= 1'b0;
        wait_all_answers();

        // random starts; every third block of ten runs with no gaps
        for (i = 0; i < RANDOM_STARTS; i++)
        begin
            burst = ((i / 10) % 3 == 1);
            if (i == RANDOM_STARTS / 2)
            begin
                start <= 1'b0;
                wait_all_answers();
            end
            issue_search(draw_start_value(), burst ? 0 : $urandom_range(0, 5));
        end

        start <= 1'b0;
        wait_all_answers();
        repeat (TAIL_CYCLES) @(negedge clk);

        if (mismatch_count == 0)
            $display("next_prime_search_core regression: pass");
        else
            $display("next_prime_search_core regression: fail");
        $finish;
    end

endmodule
